// ===== src/cce_pkg.sv =====
// Shared types, constants and codes for the text console cursor engine.
// Depends on nothing; cce_front, cce_queue, cce_back and the top level import it.
package cce_pkg;

   localparam int LINE_SIZE     = 128;
   localparam int CURSOR_HEIGHT = 16;

   localparam int CNT_W = $clog2(LINE_SIZE);
   localparam int IDX_W = 7;
   localparam int LEN_W = 7;
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QAW         = $clog2(QUEUE_DEPTH);

   localparam int PADDR_W   = 5;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_FG_COLOR    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_BG_COLOR    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CELL_WIDTH  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CELL_HEIGHT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SCREEN_COLS = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SCREEN_ROWS = 3'd5;

   localparam logic [31:0] RST_FG_COLOR    = 32'h00FF_FFFF;
   localparam logic [31:0] RST_BG_COLOR    = 32'h0000_0000;
   localparam logic [7:0]  RST_CELL_WIDTH  = 8'd8;
   localparam logic [7:0]  RST_CELL_HEIGHT = 8'd16;
   localparam logic [7:0]  RST_SCREEN_COLS = 8'd80;
   localparam logic [7:0]  RST_SCREEN_ROWS = 8'd25;

   localparam logic [2:0] CMD_PUT   = 3'd0;
   localparam logic [2:0] CMD_KEY   = 3'd1;
   localparam logic [2:0] CMD_START = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;

   localparam logic [1:0] OP_STATUS = 2'd0;
   localparam logic [1:0] OP_FILL   = 2'd1;
   localparam logic [1:0] OP_RECT   = 2'd2;
   localparam logic [1:0] OP_GLYPH  = 2'd3;

   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_BS = 8'h08;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_PUT,
      KIND_CLEAR
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STATUS,
      ST_ERASE,
      ST_GLYPH,
      ST_CELL,
      ST_FILL,
      ST_BAR
   } step_type;

   typedef struct packed {
      logic [31:0] fg_color;
      logic [31:0] bg_color;
      logic [7:0]  cell_width;
      logic [7:0]  cell_height;
      logic [7:0]  screen_cols;
      logic [7:0]  screen_rows;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        ch;
      logic              line_complete;
      logic [LEN_W-1:0]  line_length;
      logic [7:0]        line_byte;
   } q_entry_type;

endpackage

// ===== src/cce_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module cce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cce_front.sv =====
// Front end: accepts items, keeps the line-editing state and classifies items.
// Depends on cce_pkg and cce_ram.
module cce_front import cce_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_cmd,
   input  logic [7:0]       req_char_code,
   input  logic [IDX_W-1:0] req_byte_index,
   input  logic             q_full,
   output logic             q_push,
   output q_entry_type      q_data
);

   logic             accept;
   logic             s1_valid_ff, s1_valid_in;
   q_entry_type      s1_entry_ff, s1_entry_in;
   logic             s1_rd_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             done_ff, done_in;
   logic [7:0]       key_ch;
   logic             wr_en;
   logic             rd_hit;
   logic [7:0]       ram_q;

   assign q_push      = s1_valid_ff && !q_full;
   assign req_stall   = s1_valid_ff && q_full;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !q_push);

   always_comb begin
      count_in          = count_ff;
      done_in           = done_ff;
      wr_en             = 1'b0;
      rd_hit            = 1'b0;
      key_ch            = (req_char_code == CH_CR) ? CH_NL : req_char_code;
      s1_entry_in       = '0;
      s1_entry_in.kind  = KIND_NONE;
      s1_entry_in.ch    = req_char_code;
      unique case (req_cmd)
         CMD_PUT: begin
            s1_entry_in.kind = KIND_PUT;
         end
         CMD_KEY: begin
            if (key_ch == CH_BS) begin
               if (count_ff != '0) begin
                  count_in         = count_ff - CNT_W'(1);
                  s1_entry_in.kind = KIND_PUT;
               end
            end else if (key_ch == CH_NL) begin
               done_in          = 1'b1;
               s1_entry_in.kind = KIND_PUT;
               s1_entry_in.ch   = CH_NL;
            end else if (({1'b0, count_ff} + (CNT_W+1)'(1)) < (CNT_W+1)'(LINE_SIZE)) begin
               wr_en            = 1'b1;
               count_in         = count_ff + CNT_W'(1);
               s1_entry_in.kind = KIND_PUT;
            end
         end
         CMD_START: begin
            count_in = '0;
            done_in  = 1'b0;
         end
         CMD_READ: begin
            rd_hit = CMP_W'(req_byte_index) < CMP_W'(count_ff);
         end
         CMD_CLEAR: begin
            s1_entry_in.kind = KIND_CLEAR;
         end
         default: begin
         end
      endcase
      s1_entry_in.line_complete = done_in;
      s1_entry_in.line_length   = LEN_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         count_ff    <= '0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            count_ff <= count_in;
            done_ff  <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_entry_ff <= s1_entry_in;
         s1_rd_ff    <= rd_hit;
      end
   end

   cce_ram #(
      .WIDTH(8),
      .DEPTH(LINE_SIZE)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en && accept),
      .wr_addr (count_ff),
      .wr_data (req_char_code),
      .rd_en   (accept),
      .rd_addr (CNT_W'(req_byte_index)),
      .rd_data (ram_q)
   );

   always_comb begin
      q_data           = s1_entry_ff;
      q_data.line_byte = s1_rd_ff ? ram_q : 8'd0;
   end

endmodule

// ===== src/cce_queue.sv =====
// Short FIFO of classified items between the front end and the back end.
// Depends on cce_pkg.
module cce_queue import cce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_data,
   output logic        full,
   input  logic        pop,
   output q_entry_type head,
   output logic        empty
);

   q_entry_type    entries_ff [QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]   count_ff, count_in;

   assign full  = (count_ff == (QAW+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QAW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QAW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/cce_back.sv =====
// Back end: owns the cursor and emits the drawing results of each item.
// Depends on cce_pkg.
module cce_back import cce_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  q_entry_type       q_head,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_draw_op,
   output logic [15:0]       rsp_x_pixel,
   output logic [15:0]       rsp_y_pixel,
   output logic [7:0]        rsp_rect_width,
   output logic [7:0]        rsp_rect_height,
   output logic [31:0]       rsp_color,
   output logic [7:0]        rsp_glyph,
   output logic              rsp_last,
   output logic              rsp_line_complete,
   output logic [LEN_W-1:0]  rsp_line_length,
   output logic [7:0]        rsp_line_byte
);

   step_type         state_ff, state_in;
   logic [7:0]       col_ff, col_in;
   logic [7:0]       row_ff, row_in;
   logic [7:0]       op_ch_ff;
   logic             op_ready_ff;
   logic [LEN_W-1:0] op_len_ff;
   logic [7:0]       op_byte_ff;
   logic             out_free;
   logic             emit;
   logic             take_next;
   logic [8:0]       col_sum;
   logic [8:0]       row_sum;
   logic [15:0]      x_cell;
   logic [15:0]      y_cell;
   logic [15:0]      y_bar;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_draw_op_ff, rsp_draw_op_in;
   logic [15:0]      rsp_x_ff, rsp_x_in;
   logic [15:0]      rsp_y_ff, rsp_y_in;
   logic [7:0]       rsp_w_ff, rsp_w_in;
   logic [7:0]       rsp_h_ff, rsp_h_in;
   logic [31:0]      rsp_color_ff, rsp_color_in;
   logic [7:0]       rsp_glyph_ff, rsp_glyph_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ready_ff;
   logic [LEN_W-1:0] rsp_len_ff;
   logic [7:0]       rsp_byte_ff;

   function automatic step_type first_step(input q_entry_type e, input logic [7:0] col);
      step_type s;
      s = ST_STATUS;
      case (e.kind)
         KIND_PUT:   s = ((e.ch == CH_BS) && (col == 8'd0)) ? ST_STATUS : ST_ERASE;
         KIND_CLEAR: s = ST_FILL;
         default:    s = ST_STATUS;
      endcase
      return s;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (state_ff != ST_IDLE) && out_free;
   assign take_next = (state_ff == ST_IDLE) ||
                      (emit && ((state_ff == ST_BAR) || (state_ff == ST_STATUS)));
   assign col_sum   = {1'b0, col_ff} + 9'd1;
   assign row_sum   = {1'b0, row_ff} + 9'd1;

   // Next step and cursor movement.
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      q_pop    = 1'b0;
      if (take_next) begin
         if (!q_empty) begin
            q_pop    = 1'b1;
            state_in = first_step(q_head, col_ff);
         end else begin
            state_in = ST_IDLE;
         end
      end else if (emit) begin
         unique case (state_ff)
            ST_ERASE: begin
               case (op_ch_ff)
                  CH_NL: begin
                     col_in   = 8'd0;
                     row_in   = row_sum[7:0];
                     state_in = (row_sum >= {1'b0, cfg.screen_rows}) ? ST_FILL : ST_BAR;
                  end
                  CH_CR: begin
                     col_in   = 8'd0;
                     state_in = ST_BAR;
                  end
                  CH_BS: begin
                     col_in   = col_ff - 8'd1;
                     state_in = ST_CELL;
                  end
                  default: begin
                     state_in = ST_GLYPH;
                  end
               endcase
            end
            ST_GLYPH: begin
               if (col_sum >= {1'b0, cfg.screen_cols}) begin
                  col_in   = 8'd0;
                  row_in   = row_sum[7:0];
                  state_in = (row_sum >= {1'b0, cfg.screen_rows}) ? ST_FILL : ST_BAR;
               end else begin
                  col_in   = col_sum[7:0];
                  state_in = ST_BAR;
               end
            end
            ST_CELL: begin
               state_in = ST_BAR;
            end
            ST_FILL: begin
               col_in   = 8'd0;
               row_in   = 8'd0;
               state_in = ST_BAR;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   assign x_cell = {8'd0, col_ff} * {8'd0, cfg.cell_width};
   assign y_cell = {8'd0, row_ff} * {8'd0, cfg.cell_height};
   assign y_bar  = y_cell + {8'd0, cfg.cell_height} - 16'(CURSOR_HEIGHT);

   // Result contents for the current step.
   always_comb begin
      rsp_valid_in   = emit;
      rsp_draw_op_in = OP_STATUS;
      rsp_x_in       = 16'd0;
      rsp_y_in       = 16'd0;
      rsp_w_in       = 8'd0;
      rsp_h_in       = 8'd0;
      rsp_color_in   = 32'd0;
      rsp_glyph_in   = 8'd0;
      rsp_last_in    = 1'b0;
      unique case (state_ff)
         ST_STATUS: begin
            rsp_last_in = 1'b1;
         end
         ST_ERASE: begin
            rsp_draw_op_in = OP_RECT;
            rsp_x_in       = x_cell;
            rsp_y_in       = y_bar;
            rsp_w_in       = cfg.cell_width;
            rsp_h_in       = 8'(CURSOR_HEIGHT);
            rsp_color_in   = cfg.bg_color;
         end
         ST_BAR: begin
            rsp_draw_op_in = OP_RECT;
            rsp_x_in       = x_cell;
            rsp_y_in       = y_bar;
            rsp_w_in       = cfg.cell_width;
            rsp_h_in       = 8'(CURSOR_HEIGHT);
            rsp_color_in   = cfg.fg_color;
            rsp_last_in    = 1'b1;
         end
         ST_GLYPH: begin
            rsp_draw_op_in = OP_GLYPH;
            rsp_x_in       = x_cell;
            rsp_y_in       = y_cell;
            rsp_w_in       = cfg.cell_width;
            rsp_h_in       = cfg.cell_height;
            rsp_color_in   = cfg.fg_color;
            rsp_glyph_in   = op_ch_ff;
         end
         ST_CELL: begin
            rsp_draw_op_in = OP_RECT;
            rsp_x_in       = x_cell;
            rsp_y_in       = y_cell;
            rsp_w_in       = cfg.cell_width;
            rsp_h_in       = cfg.cell_height;
            rsp_color_in   = cfg.bg_color;
         end
         ST_FILL: begin
            rsp_draw_op_in = OP_FILL;
            rsp_color_in   = cfg.bg_color;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= 8'd0;
         row_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (out_free) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ch_ff    <= q_head.ch;
         op_ready_ff <= q_head.line_complete;
         op_len_ff   <= q_head.line_length;
         op_byte_ff  <= q_head.line_byte;
      end
      if (emit) begin
         rsp_draw_op_ff <= rsp_draw_op_in;
         rsp_x_ff       <= rsp_x_in;
         rsp_y_ff       <= rsp_y_in;
         rsp_w_ff       <= rsp_w_in;
         rsp_h_ff       <= rsp_h_in;
         rsp_color_ff   <= rsp_color_in;
         rsp_glyph_ff   <= rsp_glyph_in;
         rsp_last_ff    <= rsp_last_in;
         rsp_ready_ff   <= op_ready_ff;
         rsp_len_ff     <= op_len_ff;
         rsp_byte_ff    <= op_byte_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_draw_op       = rsp_draw_op_ff;
   assign rsp_x_pixel       = rsp_x_ff;
   assign rsp_y_pixel       = rsp_y_ff;
   assign rsp_rect_width    = rsp_w_ff;
   assign rsp_rect_height   = rsp_h_ff;
   assign rsp_color         = rsp_color_ff;
   assign rsp_glyph         = rsp_glyph_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_line_complete = rsp_ready_ff;
   assign rsp_line_length   = rsp_len_ff;
   assign rsp_line_byte     = rsp_byte_ff;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("item taken from an empty queue");

   a_fill_then_bar: assert property (@(posedge clock) disable iff (reset)
      (emit && (state_ff == ST_FILL)) |=> (state_ff == ST_BAR))
      else $error("screen clear not followed by the cursor bar");

   a_glyph_next: assert property (@(posedge clock) disable iff (reset)
      (emit && (state_ff == ST_GLYPH)) |=> ((state_ff == ST_BAR) || (state_ff == ST_FILL)))
      else $error("glyph not followed by cursor bar or clear");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (emit && (state_ff == ST_STATUS)) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("status result not marked as final");

endmodule

// ===== src/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine: configuration registers and
// the front end, queue and back end. Depends on cce_pkg, cce_front,
// cce_queue and cce_back.
//
// Console commands enter on the req_ channel; drawing commands leave on the
// rsp_ channel, each a single item. A channel moves an item at a rising edge
// with valid high and stall low. Each input item gives one to four result
// items, the final one flagged by rsp_last, in order and one per cycle while
// rsp_stall is low. An item passes the front-end stage register, a queue
// entry and the back-end step register before its first result is
// registered. Sustained throughput is one result per cycle while rsp_stall
// is low. A four-entry queue between front and back end lets the front
// keep taking items while the receiver stalls; once the queue is full and
// the front-end stage holds an item, req_stall rises.
// The line buffer is a 128-byte RAM with a registered read port.
// Reset is synchronous: cursor home, empty line, registers at their defaults;
// there is no clearing pass and the block takes items in the next cycle.
// Registers sit on the APB-style port at byte address 4 times their index.
module text_console_cursor_engine import cce_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic [7:0]         req_char_code,
   input  logic [IDX_W-1:0]   req_byte_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_draw_op,
   output logic [15:0]        rsp_x_pixel,
   output logic [15:0]        rsp_y_pixel,
   output logic [7:0]         rsp_rect_width,
   output logic [7:0]         rsp_rect_height,
   output logic [31:0]        rsp_color,
   output logic [7:0]         rsp_glyph,
   output logic               rsp_last,
   output logic               rsp_line_complete,
   output logic [LEN_W-1:0]   rsp_line_length,
   output logic [7:0]         rsp_line_byte,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   cfg_type              cfg_ff;
   logic                 csr_write;
   logic [REG_IDX_W-1:0] csr_index;
   logic                 q_push;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_empty;
   q_entry_type          q_data;
   q_entry_type          q_head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[PADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fg_color    <= RST_FG_COLOR;
         cfg_ff.bg_color    <= RST_BG_COLOR;
         cfg_ff.cell_width  <= RST_CELL_WIDTH;
         cfg_ff.cell_height <= RST_CELL_HEIGHT;
         cfg_ff.screen_cols <= RST_SCREEN_COLS;
         cfg_ff.screen_rows <= RST_SCREEN_ROWS;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FG_COLOR:    cfg_ff.fg_color    <= pwdata;
            REG_BG_COLOR:    cfg_ff.bg_color    <= pwdata;
            REG_CELL_WIDTH:  cfg_ff.cell_width  <= pwdata[7:0];
            REG_CELL_HEIGHT: cfg_ff.cell_height <= pwdata[7:0];
            REG_SCREEN_COLS: cfg_ff.screen_cols <= pwdata[7:0];
            REG_SCREEN_ROWS: cfg_ff.screen_rows <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_FG_COLOR:    prdata = cfg_ff.fg_color;
         REG_BG_COLOR:    prdata = cfg_ff.bg_color;
         REG_CELL_WIDTH:  prdata = {24'd0, cfg_ff.cell_width};
         REG_CELL_HEIGHT: prdata = {24'd0, cfg_ff.cell_height};
         REG_SCREEN_COLS: prdata = {24'd0, cfg_ff.screen_cols};
         REG_SCREEN_ROWS: prdata = {24'd0, cfg_ff.screen_rows};
         default:         prdata = 32'd0;
      endcase
   end

   cce_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_byte_index (req_byte_index),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_data)
   );

   cce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   cce_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_head            (q_head),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_draw_op       (rsp_draw_op),
      .rsp_x_pixel       (rsp_x_pixel),
      .rsp_y_pixel       (rsp_y_pixel),
      .rsp_rect_width    (rsp_rect_width),
      .rsp_rect_height   (rsp_rect_height),
      .rsp_color         (rsp_color),
      .rsp_glyph         (rsp_glyph),
      .rsp_last          (rsp_last),
      .rsp_line_complete (rsp_line_complete),
      .rsp_line_length   (rsp_line_length),
      .rsp_line_byte     (rsp_line_byte)
   );

endmodule
